FILE: design/tmpt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the task max-priority table.
package tmpt_pkg;

	localparam int OPCODE_W   = 2;
	localparam int TASK_ID_W  = 8;
	localparam int USER_ID_W  = 16;
	localparam int PRIO_REQ_W = 32;

	localparam int DEF_TASK_ENTRIES  = 256;
	localparam int DEF_USER_BITS     = 16;
	localparam int DEF_PRIORITY_BITS = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD    = 2'd0,
		OP_EDIT   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_EXEC   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDIT,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Control from the sequencer to the best-entry tracker.
	typedef struct packed {
		logic start;
		logic step;
	} scan_ctl_t;

endpackage

FILE: design/tmpt_in_if.sv
`timescale 1ns / 1ps
// Command channel interface: valid/ready handshake with the command fields.
interface tmpt_in_if;
	logic                             valid;
	logic                             ready;
	logic [tmpt_pkg::OPCODE_W-1:0]    opcode;
	logic [tmpt_pkg::TASK_ID_W-1:0]   task_id;
	logic [tmpt_pkg::USER_ID_W-1:0]   user_id;
	logic [tmpt_pkg::PRIO_REQ_W-1:0]  priority_req;

	modport source (output valid, output opcode, output task_id, output user_id,
		output priority_req, input ready);
	modport sink (input valid, input opcode, input task_id, input user_id,
		input priority_req, output ready);
endinterface

FILE: design/tmpt_out_if.sv
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake with the result fields.
interface tmpt_out_if;
	logic                            valid;
	logic                            ready;
	logic [tmpt_pkg::USER_ID_W-1:0]  owner_user;
	logic                            empty_res;

	modport source (output valid, output owner_user, output empty_res, input ready);
	modport sink (input valid, input owner_user, input empty_res, output ready);
endinterface

FILE: design/tmpt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module tmpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/tmpt_scan.sv
`timescale 1ns / 1ps
// Best-entry tracker: keeps the highest-priority valid entry seen during a scan.
module tmpt_scan #(
	parameter int USER_BITS     = tmpt_pkg::DEF_USER_BITS,
	parameter int PRIORITY_BITS = tmpt_pkg::DEF_PRIORITY_BITS,
	parameter int IDX_W         = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tmpt_pkg::scan_ctl_t      ctl,
	input  logic [IDX_W-1:0]         entry_idx,
	input  logic                     entry_valid,
	input  logic [USER_BITS-1:0]     entry_user,
	input  logic [PRIORITY_BITS-1:0] entry_prio,
	output logic                     found,
	output logic [IDX_W-1:0]         best_idx,
	output logic [USER_BITS-1:0]     best_user
);

	logic                     found_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [USER_BITS-1:0]     best_user_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic                     take;

	// Entries arrive in ascending order, so >= lets the higher index win a tie.
	assign take = ctl.step && entry_valid && (!found_q || entry_prio >= best_prio_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= entry_idx;
			best_user_q <= entry_user;
			best_prio_q <= entry_prio;
		end
	end

	assign found     = found_q;
	assign best_idx  = best_idx_q;
	assign best_user = best_user_q;

endmodule

FILE: design/task_max_priority_table_top.sv
`timescale 1ns / 1ps
// Task max-priority table: sequencer, table memory and result register.
//
// Commands arrive on cmd (opcode, task_id, user_id, priority_req) with a
// valid/ready transfer; results leave on res (owner_user, empty_res).
// Add and remove give no result. Edit reads the entry and writes it back,
// no result. Execute-top gives one result: it issues one table read per
// cycle through the memory's single read port over every entry, then loads
// the result, and the winning entry is invalidated in the same cycle.
// Commands ids at or beyond TASK_ENTRIES are ignored.
// The block takes one command at a time; cmd.ready is high only while it
// waits for a command.
// After reset the table is cleared by writing every entry once, and
// cmd.ready stays low meanwhile.
// The result sits in an output register; while the receiver stalls, the
// block keeps accepting add, edit and remove, and a further execute-top
// waits at its end until the register is free.
module task_max_priority_table_top #(
	parameter int TASK_ENTRIES  = tmpt_pkg::DEF_TASK_ENTRIES,
	parameter int USER_BITS     = tmpt_pkg::DEF_USER_BITS,
	parameter int PRIORITY_BITS = tmpt_pkg::DEF_PRIORITY_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	tmpt_in_if.sink  cmd,
	tmpt_out_if.source res
);

	localparam int IDX_W = $clog2(TASK_ENTRIES);
	localparam int MEM_W = 1 + USER_BITS + PRIORITY_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_ENTRIES - 1);

	tmpt_pkg::state_t    state_q, state_d;
	tmpt_pkg::scan_ctl_t scan_ctl;

	logic [IDX_W-1:0]         cnt_q, cnt_d;
	logic [IDX_W-1:0]         op_idx_q;
	logic [PRIORITY_BITS-1:0] op_prio_q;

	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	logic [MEM_W-1:0] mem_wdata, mem_rdata;

	logic                     rd_valid;
	logic [USER_BITS-1:0]     rd_user;
	logic [PRIORITY_BITS-1:0] rd_prio;

	logic [31:0]              id_ext, user_ext, owner_ext;
	logic [IDX_W-1:0]         in_idx;
	logic                     in_range;
	logic [USER_BITS-1:0]     in_user;
	logic [PRIORITY_BITS-1:0] in_prio;
	logic                     in_xfer;

	logic                     found;
	logic [IDX_W-1:0]         best_idx;
	logic [USER_BITS-1:0]     best_user;

	logic                             out_valid_q;
	logic [tmpt_pkg::USER_ID_W-1:0]   owner_user_q;
	logic                             empty_res_q;
	logic                             out_free, out_load;

	assign id_ext   = 32'(cmd.task_id);
	assign in_idx   = id_ext[IDX_W-1:0];
	assign in_range = id_ext < 32'(TASK_ENTRIES);
	assign user_ext = 32'(cmd.user_id);
	assign in_user  = user_ext[USER_BITS-1:0];
	assign in_prio  = cmd.priority_req[PRIORITY_BITS-1:0];
	assign in_xfer  = cmd.valid && cmd.ready;

	assign rd_valid = mem_rdata[MEM_W-1];
	assign rd_user  = mem_rdata[PRIORITY_BITS +: USER_BITS];
	assign rd_prio  = mem_rdata[PRIORITY_BITS-1:0];

	assign out_free = !out_valid_q || res.ready;

	tmpt_ram #(
		.WIDTH (MEM_W),
		.DEPTH (TASK_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tmpt_scan #(
		.USER_BITS     (USER_BITS),
		.PRIORITY_BITS (PRIORITY_BITS),
		.IDX_W         (IDX_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.entry_idx   (cnt_q),
		.entry_valid (rd_valid),
		.entry_user  (rd_user),
		.entry_prio  (rd_prio),
		.found       (found),
		.best_idx    (best_idx),
		.best_user   (best_user)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmpt_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_idx_q  <= in_idx;
			op_prio_q <= in_prio;
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd.ready     = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = cnt_q;
		mem_wdata     = '0;
		mem_re        = 1'b0;
		mem_raddr     = cnt_q + IDX_W'(1);
		scan_ctl      = '0;
		out_load      = 1'b0;
		unique case (state_q)
			tmpt_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + IDX_W'(1);
				if (cnt_q == LAST_IDX) begin
					state_d = tmpt_pkg::ST_IDLE;
				end
			end
			tmpt_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					unique case (tmpt_pkg::opcode_t'(cmd.opcode))
						tmpt_pkg::OP_ADD: begin
							mem_we    = in_range;
							mem_waddr = in_idx;
							mem_wdata = {1'b1, in_user, in_prio};
						end
						tmpt_pkg::OP_EDIT: begin
							if (in_range) begin
								mem_re    = 1'b1;
								mem_raddr = in_idx;
								state_d   = tmpt_pkg::ST_EDIT;
							end
						end
						tmpt_pkg::OP_REMOVE: begin
							mem_we    = in_range;
							mem_waddr = in_idx;
						end
						tmpt_pkg::OP_EXEC: begin
							mem_re         = 1'b1;
							mem_raddr      = '0;
							cnt_d          = '0;
							scan_ctl.start = 1'b1;
							state_d        = tmpt_pkg::ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			tmpt_pkg::ST_EDIT: begin
				// An edit of an absent task leaves the entry alone.
				mem_we    = rd_valid;
				mem_waddr = op_idx_q;
				mem_wdata = {1'b1, rd_user, op_prio_q};
				state_d   = tmpt_pkg::ST_IDLE;
			end
			tmpt_pkg::ST_SCAN: begin
				scan_ctl.step = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = tmpt_pkg::ST_DONE;
				end else begin
					mem_re = 1'b1;
					cnt_d  = cnt_q + IDX_W'(1);
				end
			end
			tmpt_pkg::ST_DONE: begin
				if (out_free) begin
					out_load  = 1'b1;
					mem_we    = found;
					mem_waddr = best_idx;
					state_d   = tmpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmpt_pkg::ST_IDLE;
			end
		endcase
	end

	assign owner_ext = 32'(best_user);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			owner_user_q <= found ? owner_ext[tmpt_pkg::USER_ID_W-1:0] : '0;
			empty_res_q  <= !found;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.owner_user = owner_user_q;
	assign res.empty_res  = empty_res_q;

	// The table is never written while a scan reads it.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tmpt_pkg::ST_SCAN |-> !mem_we)
		else $error("table written during execute-top scan");

	// The scan index advances by one each cycle until the last entry.
	a_scan_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmpt_pkg::ST_SCAN && cnt_q != LAST_IDX)
		|=> (state_q == tmpt_pkg::ST_SCAN && cnt_q == $past(cnt_q) + IDX_W'(1)))
		else $error("scan index skipped or scan left early");

	// A result is never loaded over one that the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("pending result overwritten");

	// An empty result always carries a zero owner.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.empty_res) |-> res.owner_user == '0)
		else $error("empty result with nonzero owner");

endmodule
